// ===== rtl/rk4im_pkg.sv =====
// Shared types, register indexes, operation codes and constants of the RK4 step unit.
`default_nettype none
package rk4im_pkg;

  localparam int unsigned NUM_VARIABLES = 4;
  localparam int unsigned HALF_SAT_DEF  = 1000;
  localparam int unsigned SW            = 48;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned MUL_OP_W      = 48;
  localparam int unsigned PROD_W        = 96;
  localparam int unsigned DIV_NUM_W     = 81;
  localparam int unsigned DIV_DEN_W     = 60;
  localparam int unsigned QUOT_W        = 48;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TDEATH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFECT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEATH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VPROD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VCLEAR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECTOR   = 3'd7;

  localparam logic [3:0] OP_XV  = 4'd0;
  localparam logic [3:0] OP_INF = 4'd1;
  localparam logic [3:0] OP_EY  = 4'd2;
  localparam logic [3:0] OP_TD  = 4'd3;
  localparam logic [3:0] OP_TAD = 4'd4;
  localparam logic [3:0] OP_TK  = 4'd5;
  localparam logic [3:0] OP_TP  = 4'd6;
  localparam logic [3:0] OP_TC  = 4'd7;
  localparam logic [3:0] OP_TDE = 4'd8;
  localparam logic [3:0] OP_AE  = 4'd9;

  localparam logic [1:0] STAGE_LAST = 2'd3;
  localparam logic [1:0] VAR_LAST   = 2'd3;

  typedef struct packed {
    logic                 req_type;
    logic signed [SW-1:0] load_target;
    logic signed [SW-1:0] load_infected;
    logic signed [SW-1:0] load_virus;
    logic signed [SW-1:0] load_effector;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] target_out;
    logic signed [SW-1:0] infected_out;
    logic signed [SW-1:0] virus_out;
    logic signed [SW-1:0] effector_out;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic       load_y;
    logic       init;
    logic       mul_start;
    logic       mul_cap;
    logic       div_start;
    logic       div_cap;
    logic       div_eff;
    logic       stage_end;
    logic       out_load;
    logic [3:0] op;
    logic [1:0] stage;
    logic [1:0] var_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rk4im_mul.sv =====
// Shared multiplier: 48x48 magnitudes in four 24x24 partial products, then round and clip.
`default_nettype none
module rk4im_mul (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [rk4im_pkg::MUL_OP_W-1:0]         a_i,
  input  wire logic [rk4im_pkg::MUL_OP_W-1:0]         b_i,
  input  wire logic                                   neg_i,
  input  wire logic [5:0]                             sh_i,
  output logic      [rk4im_pkg::PROD_W-1:0]           prod_o,
  output logic signed [rk4im_pkg::SW-1:0]             res_o,
  output logic                                        clip_o,
  output logic                                        done_o
);

  logic [rk4im_pkg::MUL_OP_W-1:0] a_q, b_q;
  logic                           neg_q;
  logic [5:0]                     sh_q;
  logic [rk4im_pkg::PROD_W-1:0]   acc_q;
  logic [2:0]                     cnt_q;
  logic                           busy_q, done_q;
  logic signed [rk4im_pkg::SW-1:0] res_q;
  logic                           clip_q;

  logic [23:0] a_part, b_part;
  logic [47:0] pp;
  logic [6:0]  pp_shift;
  logic [rk4im_pkg::PROD_W:0] rnd_sum, rnd_sh;
  logic [rk4im_pkg::SW-1:0]   lim, mag;
  logic                       rnd_clip;
  logic signed [rk4im_pkg::SW-1:0] rnd_res;

  always_comb begin
    a_part   = cnt_q[0] ? a_q[47:24] : a_q[23:0];
    b_part   = cnt_q[1] ? b_q[47:24] : b_q[23:0];
    pp       = 48'(a_part) * 48'(b_part);
    pp_shift = (cnt_q[0] ? 7'd24 : 7'd0) + (cnt_q[1] ? 7'd24 : 7'd0);
    rnd_sum  = {1'b0, acc_q} + ((rk4im_pkg::PROD_W+1)'(1) << (sh_q - 6'd1));
    rnd_sh   = rnd_sum >> sh_q;
    lim      = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    rnd_clip = rnd_sh > (rk4im_pkg::PROD_W+1)'(lim);
    mag      = rnd_sh[rk4im_pkg::SW-1:0];
    if (rnd_clip) begin
      rnd_res = neg_q ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      rnd_res = neg_q ? $signed(48'(-mag)) : $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= neg_i;
      sh_q  <= sh_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        res_q  <= rnd_res;
        clip_q <= rnd_clip;
      end else begin
        acc_q <= acc_q + (rk4im_pkg::PROD_W'(pp) << pp_shift);
      end
    end
  end

  assign prod_o = acc_q;
  assign res_o  = res_q;
  assign clip_o = clip_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/rk4im_div.sv =====
// Shared restoring divider: one quotient bit per cycle, 48-bit quotient with overflow flag.
`default_nettype none
module rk4im_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rk4im_pkg::DIV_NUM_W-1:0]   num_i,
  input  wire logic [rk4im_pkg::DIV_DEN_W-1:0]   den_i,
  output logic      [rk4im_pkg::QUOT_W-1:0]      q_o,
  output logic                                   ovf_o,
  output logic                                   done_o
);

  localparam int unsigned NW = rk4im_pkg::DIV_NUM_W;
  localparam int unsigned DW = rk4im_pkg::DIV_DEN_W;
  localparam int unsigned QW = rk4im_pkg::QUOT_W;

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] low_q;
  logic          ovf_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;

  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial = {rem_q, low_q[QW-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= DW'(num_i[NW-1:QW]) >= den_i;
      rem_q <= DW'(num_i[NW-1:QW]);
      low_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      low_q <= {low_q[QW-2:0], fits};
    end
  end

  assign q_o    = low_q;
  assign ovf_o  = ovf_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/rk4im_dp.sv =====
// Datapath: rate registers, state, stage terms, RK4 accumulation, shared arithmetic units.
`default_nettype none
module rk4im_dp #(
  parameter int HALF_SAT = rk4im_pkg::HALF_SAT_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rk4im_pkg::in_t                       in_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rk4im_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [rk4im_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire rk4im_pkg::ctrl_cmd_t                 cmd_i,
  output rk4im_pkg::ctrl_sts_t                      sts_o,
  output rk4im_pkg::out_t                           out_o
);

  localparam int unsigned SW = rk4im_pkg::SW;
  localparam int unsigned AW = 51;
  localparam int unsigned XW = 52;
  localparam int unsigned NV = rk4im_pkg::NUM_VARIABLES;
  localparam logic [SW-1:0] THETA = SW'(HALF_SAT) << 16;
  localparam logic signed [XW-1:0] MAXV = 52'sh7FFF_FFFF_FFFF;
  localparam logic signed [XW-1:0] MINV = -52'sh8000_0000_0000;
  // 2^26 = 6 * SIX_HI + 4; SIX_RECIP = ceil(2^34 / 6)
  localparam logic [23:0] SIX_HI    = 24'd11184810;
  localparam logic [31:0] SIX_RECIP = 32'hAAAA_AAAB;

  function automatic logic [SW:0] sat48(input logic signed [XW-1:0] v);
    if (v > MAXV) return {1'b1, MAXV[SW-1:0]};
    if (v < MINV) return {1'b1, MINV[SW-1:0]};
    return {1'b0, v[SW-1:0]};
  endfunction

  function automatic logic [SW-1:0] mag48(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  logic [47:0] supply_q, tdeath_q, infect_q, ideath_q, kill_q, vprod_q, vclear_q;
  logic [63:0] eff_q;

  logic signed [SW-1:0] y_q [NV];
  logic signed [SW-1:0] t_q [NV];
  logic signed [AW-1:0] acc_q [NV];
  logic signed [SW-1:0] xv_q, inf_q, ey_q, td_q, tad_q, tk_q, tp_q, tc_q, tde_q, eg_q;
  logic                 clip_q;
  rk4im_pkg::out_t      out_q;

  logic [SW-1:0]        mul_a, mul_b;
  logic                 mul_neg;
  logic [5:0]           mul_sh;
  logic [rk4im_pkg::PROD_W-1:0] mul_prod;
  logic signed [SW-1:0] mul_res;
  logic                 mul_clip, mul_done;

  logic [rk4im_pkg::DIV_NUM_W-1:0] div_num;
  logic [rk4im_pkg::DIV_DEN_W-1:0] div_den;
  logic [rk4im_pkg::QUOT_W-1:0]    div_q;
  logic                            div_ovf, div_done;

  logic signed [SW:0]   den;
  logic                 den_pos;
  logic [SW-1:0]        eg_lim;
  logic                 eg_clip;
  logic signed [SW-1:0] eg_val;
  logic [AW-1:0]        acc_mag;
  logic [AW-1:0]        q6_num;
  logic [SW-1:0]        q6_hi_q;
  logic [27:0]          q6_lo_q;
  logic [SW-1:0]        q6;
  logic signed [XW-1:0] inc, fin_sum;
  logic [SW:0]          fin_sat;

  logic signed [XW-1:0] s16;
  logic signed [XW-1:0] k_raw [NV];
  logic [SW:0]          k_sat [NV];
  logic signed [SW-1:0] k_val [NV];
  logic signed [XW-1:0] t_raw [NV];
  logic [SW:0]          t_sat [NV];
  logic                 stage_clip;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_sh  = 6'd40;
    case (cmd_i.op)
      rk4im_pkg::OP_XV: begin
        mul_a = mag48(t_q[0]); mul_b = mag48(t_q[2]);
        mul_neg = t_q[0][SW-1] ^ t_q[2][SW-1]; mul_sh = 6'd16;
      end
      rk4im_pkg::OP_INF: begin
        mul_a = infect_q; mul_b = mag48(xv_q); mul_neg = xv_q[SW-1];
      end
      rk4im_pkg::OP_EY: begin
        mul_a = mag48(t_q[1]); mul_b = mag48(t_q[3]);
        mul_neg = t_q[1][SW-1] ^ t_q[3][SW-1]; mul_sh = 6'd16;
      end
      rk4im_pkg::OP_TD: begin
        mul_a = tdeath_q; mul_b = mag48(t_q[0]); mul_neg = t_q[0][SW-1];
      end
      rk4im_pkg::OP_TAD: begin
        mul_a = ideath_q; mul_b = mag48(t_q[1]); mul_neg = t_q[1][SW-1];
      end
      rk4im_pkg::OP_TK: begin
        mul_a = kill_q; mul_b = mag48(ey_q); mul_neg = ey_q[SW-1];
      end
      rk4im_pkg::OP_TP: begin
        mul_a = vprod_q; mul_b = mag48(t_q[1]); mul_neg = t_q[1][SW-1];
      end
      rk4im_pkg::OP_TC: begin
        mul_a = vclear_q; mul_b = mag48(t_q[2]); mul_neg = t_q[2][SW-1];
      end
      rk4im_pkg::OP_TDE: begin
        mul_a = SW'(eff_q[31:0]); mul_b = mag48(t_q[3]);
        mul_neg = t_q[3][SW-1]; mul_sh = 6'd28;
      end
      rk4im_pkg::OP_AE: begin
        mul_a = SW'(eff_q[63:32]); mul_b = mag48(t_q[1]); mul_sh = 6'd16;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  rk4im_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .neg_i   (mul_neg),
    .sh_i    (mul_sh),
    .prod_o  (mul_prod),
    .res_o   (mul_res),
    .clip_o  (mul_clip),
    .done_o  (mul_done)
  );

  always_comb begin
    den     = $signed({1'b0, THETA}) + (SW+1)'(t_q[1]);
    den_pos = !den[SW] && (den != '0);
    acc_mag = acc_q[cmd_i.var_idx][AW-1] ? AW'(-acc_q[cmd_i.var_idx])
                                         : AW'(acc_q[cmd_i.var_idx]);
    q6_num  = acc_mag + AW'(3);
    div_num = mul_prod[rk4im_pkg::DIV_NUM_W-1:0]
            + (rk4im_pkg::DIV_NUM_W'(den[SW-1:0]) << 11);
    div_den = rk4im_pkg::DIV_DEN_W'(den[SW-1:0]) << 12;
  end

  rk4im_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start & cmd_i.div_eff),
    .num_i   (div_num),
    .den_i   (div_den),
    .q_o     (div_q),
    .ovf_o   (div_ovf),
    .done_o  (div_done)
  );

  always_comb begin
    eg_lim  = t_q[1][SW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    eg_clip = div_ovf || (div_q > eg_lim);
    if (!den_pos) begin
      eg_val = '0;
    end else if (eg_clip) begin
      eg_val = t_q[1][SW-1] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      eg_val = t_q[1][SW-1] ? $signed(SW'(-div_q)) : $signed(div_q);
    end
    q6      = q6_hi_q + SW'((60'(q6_lo_q) * 60'(SIX_RECIP)) >> 34);
    inc     = acc_q[cmd_i.var_idx][AW-1] ? -$signed(XW'(q6)) : $signed(XW'(q6));
    fin_sum = XW'(y_q[cmd_i.var_idx]) + inc;
    fin_sat = sat48(fin_sum);
  end

  always_comb begin
    s16 = $signed(XW'((49'(supply_q) + 49'(24'h80_0000)) >> 24));
    k_raw[0] = s16 - XW'(td_q) - XW'(inf_q);
    k_raw[1] = XW'(inf_q) - XW'(tad_q) - XW'(tk_q);
    k_raw[2] = XW'(tp_q) - XW'(tc_q);
    k_raw[3] = XW'(eg_q) - XW'(tde_q);
    stage_clip = 1'b0;
    for (int i = 0; i < NV; i++) begin
      k_sat[i] = sat48(k_raw[i]);
      k_val[i] = $signed(k_sat[i][SW-1:0]);
      if (cmd_i.stage == 2'd2) begin
        t_raw[i] = XW'(y_q[i]) + XW'(k_val[i]);
      end else begin
        t_raw[i] = XW'(y_q[i]) + XW'(k_val[i] >>> 1);
      end
      t_sat[i] = sat48(t_raw[i]);
      stage_clip = stage_clip | k_sat[i][SW]
                 | (t_sat[i][SW] & (cmd_i.stage != rk4im_pkg::STAGE_LAST));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= '0;
      tdeath_q <= '0;
      infect_q <= '0;
      ideath_q <= '0;
      kill_q   <= '0;
      vprod_q  <= '0;
      vclear_q <= '0;
      eff_q    <= '0;
      for (int i = 0; i < NV; i++) begin
        y_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rk4im_pkg::CFG_SUPPLY:   supply_q <= cfg_data_i[47:0];
          rk4im_pkg::CFG_TDEATH:   tdeath_q <= cfg_data_i[47:0];
          rk4im_pkg::CFG_INFECT:   infect_q <= cfg_data_i[47:0];
          rk4im_pkg::CFG_IDEATH:   ideath_q <= cfg_data_i[47:0];
          rk4im_pkg::CFG_KILL:     kill_q   <= cfg_data_i[47:0];
          rk4im_pkg::CFG_VPROD:    vprod_q  <= cfg_data_i[47:0];
          rk4im_pkg::CFG_VCLEAR:   vclear_q <= cfg_data_i[47:0];
          rk4im_pkg::CFG_EFFECTOR: eff_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load_y) begin
        y_q[0] <= in_i.load_target;
        y_q[1] <= in_i.load_infected;
        y_q[2] <= in_i.load_virus;
        y_q[3] <= in_i.load_effector;
      end else if (cmd_i.div_cap && !cmd_i.div_eff) begin
        y_q[cmd_i.var_idx] <= $signed(fin_sat[SW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_y || cmd_i.init) begin
      clip_q <= 1'b0;
    end else if (cmd_i.mul_cap && cmd_i.op != rk4im_pkg::OP_AE) begin
      clip_q <= clip_q | mul_clip;
    end else if (cmd_i.div_cap) begin
      clip_q <= clip_q | (cmd_i.div_eff ? (den_pos & eg_clip) : fin_sat[SW]);
    end else if (cmd_i.stage_end) begin
      clip_q <= clip_q | stage_clip;
    end
    if (cmd_i.init) begin
      for (int i = 0; i < NV; i++) begin
        t_q[i] <= y_q[i];
      end
    end else if (cmd_i.stage_end && cmd_i.stage != rk4im_pkg::STAGE_LAST) begin
      for (int i = 0; i < NV; i++) begin
        t_q[i] <= $signed(t_sat[i][SW-1:0]);
      end
    end
    if (cmd_i.stage_end) begin
      for (int i = 0; i < NV; i++) begin
        case (cmd_i.stage)
          2'd0:    acc_q[i] <= AW'(k_val[i]);
          2'd3:    acc_q[i] <= acc_q[i] + AW'(k_val[i]);
          default: acc_q[i] <= acc_q[i] + (AW'(k_val[i]) <<< 1);
        endcase
      end
    end
    if (cmd_i.div_start && !cmd_i.div_eff) begin
      q6_hi_q <= SW'(49'(q6_num[AW-1:26]) * 49'(SIX_HI));
      q6_lo_q <= 28'({q6_num[AW-1:26], 2'b00}) + 28'(q6_num[25:0]);
    end
    if (cmd_i.mul_cap) begin
      case (cmd_i.op)
        rk4im_pkg::OP_XV:  xv_q  <= mul_res;
        rk4im_pkg::OP_INF: inf_q <= mul_res;
        rk4im_pkg::OP_EY:  ey_q  <= mul_res;
        rk4im_pkg::OP_TD:  td_q  <= mul_res;
        rk4im_pkg::OP_TAD: tad_q <= mul_res;
        rk4im_pkg::OP_TK:  tk_q  <= mul_res;
        rk4im_pkg::OP_TP:  tp_q  <= mul_res;
        rk4im_pkg::OP_TC:  tc_q  <= mul_res;
        rk4im_pkg::OP_TDE: tde_q <= mul_res;
        default: begin
        end
      endcase
    end
    if (cmd_i.div_cap && cmd_i.div_eff) begin
      eg_q <= eg_val;
    end
    if (cmd_i.out_load) begin
      out_q.target_out   <= y_q[0];
      out_q.infected_out <= y_q[1];
      out_q.virus_out    <= y_q[2];
      out_q.effector_out <= y_q[3];
      out_q.saturated    <= clip_q;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign out_o          = out_q;

endmodule
`default_nettype wire

// ===== rtl/rk4im_ctrl.sv =====
// Controller: sequences products, divisions and stage updates of one RK4 step.
`default_nettype none
module rk4im_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   req_type_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire rk4im_pkg::ctrl_sts_t   sts_i,
  output rk4im_pkg::ctrl_cmd_t        cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_GO    = 4'd1;
  localparam logic [3:0] S_MUL_WAIT  = 4'd2;
  localparam logic [3:0] S_DIV_GO    = 4'd3;
  localparam logic [3:0] S_DIV_WAIT  = 4'd4;
  localparam logic [3:0] S_STAGE     = 4'd5;
  localparam logic [3:0] S_FDIV_GO   = 4'd6;
  localparam logic [3:0] S_FDIV_WAIT = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  logic [3:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic [1:0] stage_q, stage_d;
  logic [1:0] var_q, var_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    stage_d     = stage_q;
    var_d       = var_q;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.op      = op_q;
    cmd_o.stage   = stage_q;
    cmd_o.var_idx = var_q;
    in_ready_o    = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == rk4im_pkg::REQ_LOAD) begin
            cmd_o.load_y = 1'b1;
            state_d      = S_OUT;
          end else begin
            cmd_o.init = 1'b1;
            op_d       = rk4im_pkg::OP_XV;
            stage_d    = 2'd0;
            state_d    = S_MUL_GO;
          end
        end
      end
      S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_cap = 1'b1;
          if (op_q == rk4im_pkg::OP_AE) begin
            state_d = S_DIV_GO;
          end else begin
            op_d    = op_q + 4'd1;
            state_d = S_MUL_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_eff   = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        cmd_o.div_eff = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = S_STAGE;
        end
      end
      S_STAGE: begin
        cmd_o.stage_end = 1'b1;
        if (stage_q == rk4im_pkg::STAGE_LAST) begin
          var_d   = 2'd0;
          state_d = S_FDIV_GO;
        end else begin
          stage_d = stage_q + 2'd1;
          op_d    = rk4im_pkg::OP_XV;
          state_d = S_MUL_GO;
        end
      end
      S_FDIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_FDIV_WAIT;
      end
      S_FDIV_WAIT: begin
        cmd_o.div_cap = 1'b1;
        if (var_q == rk4im_pkg::VAR_LAST) begin
          state_d = S_OUT;
        end else begin
          var_d   = var_q + 2'd1;
          state_d = S_FDIV_GO;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= rk4im_pkg::OP_XV;
      stage_q     <= 2'd0;
      var_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      stage_q     <= stage_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/rk4_infection_model_step_unit.sv =====
// Top level of the fixed-point RK4 step unit for a four-variable infection model.
// A load transaction writes the state and presents it in the output register once
// that register is free. A step transaction runs four derivative stages, each of ten
// products on one shared multiplier, one effector division on a shared bit-serial
// divider and one stage update, then four divisions by six by reciprocal
// multiplication for the final update. One transaction is worked at a time; a
// finished result waits in the output register while the next transaction is taken.
// Configuration writes are always accepted.
`default_nettype none
module rk4_infection_model_step_unit #(
  parameter int HALF_SAT = rk4im_pkg::HALF_SAT_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire rk4im_pkg::in_t                     in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output rk4im_pkg::out_t                         out_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rk4im_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rk4im_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  rk4im_pkg::ctrl_cmd_t cmd;
  rk4im_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rk4im_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rk4im_dp #(
    .HALF_SAT (HALF_SAT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ===== test/rk4im_checker.sv =====
// Checker for the RK4 step unit: tracks configuration and state, predicts and compares results.
module rk4im_checker
  import rk4im_pkg::*;
#(
  parameter int HALF_SAT = HALF_SAT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam longint MAXV = 64'sh7FFF_FFFF_FFFF;
  localparam longint MINV = -64'sh8000_0000_0000;

  logic [47:0] supply_h, tdeath_h, infect_h, ideath_h, kill_h, vprod_h, vclear_h;
  logic [63:0] eff_rates;
  longint      cell_t, cell_i, virus, effector;
  longint      kv [4];
  bit          clip_seen;
  out_t        expected_q [$];

  function automatic longint clip48(longint v);
    if (v > MAXV) begin
      clip_seen = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      clip_seen = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  function automatic longint signed_clip(logic [127:0] mag, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (mag > lim) begin
      clip_seen = 1'b1;
      return neg ? MINV : MAXV;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] ua, ub, p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = 128'(a < 0 ? -a : a);
    ub  = 128'(b < 0 ? -b : b);
    p   = (ua * ub + (128'd1 << (sh - 1))) >> sh;
    if (ua == 0 || ub == 0) neg = 1'b0;
    return signed_clip(p, neg);
  endfunction

  function automatic longint effector_gain(longint y1);
    logic [127:0] ae, mag, ud;
    longint       den;
    ae  = 128'(eff_rates[63:32]);
    den = (longint'(HALF_SAT) <<< 16) + y1;
    if (den <= 0) return 0;
    mag = 128'(y1 < 0 ? -y1 : y1);
    if (ae == 0 || mag == 0) return 0;
    ud = 128'(den) << 12;
    return signed_clip((ae * mag + (ud >> 1)) / ud, y1 < 0);
  endfunction

  function automatic void derive(longint y0, longint y1, longint y2, longint y3);
    longint s16, xv, infl, ey;
    s16   = longint'((64'(supply_h) + 64'd8388608) >> 24);
    xv    = mul_round(y0, y2, 16);
    infl  = mul_round(xv, longint'(infect_h), 40);
    ey    = mul_round(y1, y3, 16);
    kv[0] = clip48(s16 - mul_round(longint'(tdeath_h), y0, 40) - infl);
    kv[1] = clip48(infl - mul_round(longint'(ideath_h), y1, 40)
                   - mul_round(longint'(kill_h), ey, 40));
    kv[2] = clip48(mul_round(longint'(vprod_h), y1, 40)
                   - mul_round(longint'(vclear_h), y2, 40));
    kv[3] = clip48(effector_gain(y1) - mul_round(longint'(eff_rates[31:0]), y3, 28));
  endfunction

  function automatic out_t advance_state(in_t x);
    longint y [4], t [4], k1 [4], k2 [4], k3 [4], k4 [4];
    longint sum, inc;
    out_t   r;
    clip_seen = 1'b0;
    if (x.req_type == REQ_LOAD) begin
      cell_t   = longint'(x.load_target);
      cell_i   = longint'(x.load_infected);
      virus    = longint'(x.load_virus);
      effector = longint'(x.load_effector);
    end else begin
      y[0] = cell_t; y[1] = cell_i; y[2] = virus; y[3] = effector;
      derive(y[0], y[1], y[2], y[3]);
      k1 = kv;
      for (int i = 0; i < 4; i++) t[i] = clip48(y[i] + (k1[i] >>> 1));
      derive(t[0], t[1], t[2], t[3]);
      k2 = kv;
      for (int i = 0; i < 4; i++) t[i] = clip48(y[i] + (k2[i] >>> 1));
      derive(t[0], t[1], t[2], t[3]);
      k3 = kv;
      for (int i = 0; i < 4; i++) t[i] = clip48(y[i] + k3[i]);
      derive(t[0], t[1], t[2], t[3]);
      k4 = kv;
      for (int i = 0; i < 4; i++) begin
        sum  = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
        inc  = sum >= 0 ? (sum + 3) / 6 : -((-sum + 3) / 6);
        y[i] = clip48(y[i] + inc);
      end
      cell_t = y[0]; cell_i = y[1]; virus = y[2]; effector = y[3];
    end
    r.target_out   = cell_t[47:0];
    r.infected_out = cell_i[47:0];
    r.virus_out    = virus[47:0];
    r.effector_out = effector[47:0];
    r.saturated    = clip_seen;
    return r;
  endfunction

  function automatic void report(string what, longint exp_v, longint got_v);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      supply_h  <= '0; tdeath_h <= '0; infect_h <= '0; ideath_h <= '0;
      kill_h    <= '0; vprod_h  <= '0; vclear_h <= '0; eff_rates <= '0;
      cell_t = 0; cell_i = 0; virus = 0; effector = 0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SUPPLY:   supply_h  <= cfg_data_i[47:0];
          CFG_TDEATH:   tdeath_h  <= cfg_data_i[47:0];
          CFG_INFECT:   infect_h  <= cfg_data_i[47:0];
          CFG_IDEATH:   ideath_h  <= cfg_data_i[47:0];
          CFG_KILL:     kill_h    <= cfg_data_i[47:0];
          CFG_VPROD:    vprod_h   <= cfg_data_i[47:0];
          CFG_VCLEAR:   vclear_h  <= cfg_data_i[47:0];
          CFG_EFFECTOR: eff_rates <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_i.target_out !== want.target_out)
            report("target_out", want.target_out, out_i.target_out);
          if (out_i.infected_out !== want.infected_out)
            report("infected_out", want.infected_out, out_i.infected_out);
          if (out_i.virus_out !== want.virus_out)
            report("virus_out", want.virus_out, out_i.virus_out);
          if (out_i.effector_out !== want.effector_out)
            report("effector_out", want.effector_out, out_i.effector_out);
          if (out_i.saturated !== want.saturated)
            report("saturated", want.saturated, out_i.saturated);
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(advance_state(in_i));
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ===== test/tb.sv =====
// Testbench top for the RK4 step unit: clock, reset, stimulus and verdict.
module tb;
  import rk4im_pkg::*;

  localparam int     N_PHASE_ITEMS = 640;
  localparam longint CYCLE_LIMIT   = 20_000_000;
  localparam logic [47:0] THETA    = 48'(HALF_SAT_DEF) << 16;

  logic                  clk_i, rst_ni;
  logic                  in_valid, in_ready, out_valid, out_ready;
  in_t                   in_data;
  out_t                  out_data;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending;
  int                    send_idle_pct, recv_idle_pct;
  bit                    hold_output;
  longint                cycles;

  rk4_infection_model_step_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rk4im_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rk4_infection_model_step_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_output) begin
      out_ready <= 1'b0;
      repeat (3000) @(posedge clk_i);
      hold_output = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom} >> 16;
  endfunction

  function automatic logic [47:0] rand_state();
    return 48'($signed(rand48()) >>> $urandom_range(47));
  endfunction

  function automatic logic [63:0] rand_coef();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  task automatic send(in_t x);
    in_data  <= x;
    in_valid <= 1'b1;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic pause_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_load(logic [47:0] t, logic [47:0] i, logic [47:0] v, logic [47:0] e);
    in_t x;
    x.req_type      = REQ_LOAD;
    x.load_target   = t;
    x.load_infected = i;
    x.load_virus    = v;
    x.load_effector = e;
    send(x);
  endtask

  task automatic send_step();
    in_t x;
    x = {rand48(), rand48(), rand48(), rand48(), REQ_STEP};
    x.req_type = REQ_STEP;
    send(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
  endtask

  task automatic write_all(int mode);
    logic [63:0] v;
    for (int r = 0; r < 8; r++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = rand_coef();
      endcase
      write_reg(r[CFG_IDX_W-1:0], v);
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    int cnt;
    bit held;
    cnt  = 0;
    held = 1'b0;
    while (cnt < n) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_step();
        else send_load(rand48(), rand48(), rand48(), rand48());
        cnt++;
      end else begin
        send_load(rand_state(), rand_state(), rand_state(), rand_state());
        cnt++;
        repeat ($urandom_range(2, 8)) begin
          pause_sender();
          send_step();
          cnt++;
        end
      end
      pause_sender();
      if (cnt >= n / 2 && !held && recv_idle_pct == 0) begin
        hold_output = 1'b1;
        held        = 1'b1;
      end
    end
  endtask

  task automatic directed();
    logic [47:0] mx, mn;
    mx = 48'h7FFF_FFFF_FFFF;
    mn = 48'h8000_0000_0000;
    send_step();
    send_load(mx, mx, mx, mx);
    send_load(mn, mn, mn, mn);
    send_load('0, '0, '0, '0);
    drain();
    write_all(1);
    send_step();
    send_load(mx, mx, mx, mx);
    send_step();
    send_load(mn, mn, mn, mn);
    send_step();
    send_load(48'h10000, -THETA, 48'h10000, 48'h10000);
    send_step();
    send_load(48'h10000, -THETA - 48'd1, 48'h10000, 48'h10000);
    send_step();
    send_load(48'h10000, -THETA + 48'd1, 48'h10000, 48'h10000);
    send_step();
    send_load(48'h10000, 48'h50000, 48'h10000, mn);
    send_step();
    drain();
    write_all(2);
    send_load(48'h3E8_0000, 48'h1_0000, 48'h10_0000, 48'h5_0000);
    send_step();
    send_step();
    drain();
  endtask

  initial begin
    cycles        = 0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_output   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    send_idle_pct = 17;
    recv_idle_pct = 86;
    write_all(2);
    run_random(N_PHASE_ITEMS);
    drain();
    send_idle_pct = 86;
    recv_idle_pct = 17;
    write_all(2);
    run_random(N_PHASE_ITEMS / 2);
    drain();
    write_all(1);
    run_random(N_PHASE_ITEMS / 2);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(2);
    run_random(N_PHASE_ITEMS);
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rk4_infection_model_step_unit regression: pass");
    end else begin
      $display("rk4_infection_model_step_unit regression: fail");
    end
    $finish;
  end

endmodule
